// ----- src/jlfsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package jlfsc_pkg;

    localparam int FRAC_BITS = 16;
    localparam logic [5:0] MAX_PATH_POINTS = 6'd50;

    localparam int POS_W = 29;
    localparam int VEL_W = 22;
    localparam int ACC_W = 21;
    localparam int MACC_W = 20;
    localparam int JERK_W = 21;
    localparam int DIST_W = 24;
    localparam int PTS_W = 6;
    localparam int CFG_W = 24;
    localparam int CFG_IDX_W = 3;

    localparam int PROD_W = 28;
    localparam int MUL_W = 57;
    localparam int DIV_SHIFT = 34;
    localparam int QM_W = MUL_W - DIV_SHIFT;
    localparam int Q_W = QM_W + 1;
    localparam int GAP_W = POS_W + 2;
    localparam int AW_W = 22;
    localparam int VW_W = 24;
    localparam int PC_W = 5;

    localparam logic [28:0] DIV_MAGIC = 29'd343597384;
    localparam logic [27:0] DIV_ROUND = 28'd25;

    localparam logic [VEL_W-1:0] FX_ONE = VEL_W'(1 << FRAC_BITS);
    localparam logic [VEL_W-1:0] FX_TWO = VEL_W'(2 << FRAC_BITS);

    localparam logic [VEL_W-1:0] RST_MAX_VELOCITY = 22'd1441792;
    localparam logic [MACC_W-1:0] RST_MAX_ACCEL = 20'd589824;
    localparam logic [JERK_W-1:0] RST_MAX_JERK = 21'd589824;
    localparam logic [DIST_W-1:0] RST_SAFETY_DISTANCE = 24'd1966080;
    localparam logic [DIST_W-1:0] RST_MIN_DISTANCE = 24'd655360;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_VELOCITY = 3'd0,
        REG_MAX_ACCEL = 3'd1,
        REG_MAX_JERK = 3'd2,
        REG_SAFETY_DISTANCE = 3'd3,
        REG_MIN_DISTANCE = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ACT_ACCEL = 2'd0,
        ACT_BRAKE = 2'd1,
        ACT_EMERGENCY = 2'd2
    } act_t;

    typedef struct packed {
        logic lead_present;
        logic [POS_W-1:0] lead_position;
        logic [VEL_W-1:0] lead_speed;
        logic [POS_W-1:0] ego_position;
        logic [POS_W-1:0] path_end_position;
        logic [PTS_W-1:0] queued_points;
    } item_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] accel_out;
        logic [VEL_W-1:0] velocity_out;
        logic [1:0] action;
    } result_t;

    typedef enum logic [3:0] {
        OP_NOP = 4'd0,
        OP_MUL_PTS = 4'd1,
        OP_DIV_PREP = 4'd2,
        OP_MUL_MAGIC = 4'd3,
        OP_GAPS = 4'd4,
        OP_ACC_ADD = 4'd5,
        OP_ACC_SUB = 4'd6,
        OP_ACC_NEG = 4'd7,
        OP_VEL_CAP = 4'd8,
        OP_VEL_FLOOR = 4'd9,
        OP_VEL_EMERG = 4'd10,
        OP_HOLD = 4'd11,
        OP_STORE = 4'd12
    } op_t;

    typedef enum logic [1:0] {
        SRC_MUL = 2'd0,
        SRC_JERK = 2'd1,
        SRC_ACC = 2'd2
    } src_t;

    typedef enum logic [2:0] {
        C_NEVER = 3'd0,
        C_ALWAYS = 3'd1,
        C_NO_LEAD = 3'd2,
        C_EMERG = 3'd3,
        C_BRAKE = 3'd4,
        C_AT_MAX = 3'd5,
        C_BRAKE_HOLD = 3'd6
    } cond_t;

    typedef struct packed {
        op_t op;
        src_t src;
        cond_t cond;
        logic [PC_W-1:0] target;
        logic act_we;
        act_t act;
        logic last;
    } uword_t;

    localparam logic [PC_W-1:0] UA_ACCEL = 5'd7;
    localparam logic [PC_W-1:0] UA_BRAKE = 5'd14;
    localparam logic [PC_W-1:0] UA_EMERG = 5'd21;
    localparam logic [PC_W-1:0] UA_HOLD = 5'd25;
    localparam logic [PC_W-1:0] UA_STORE = 5'd26;

    function automatic uword_t uw(op_t op, src_t src, cond_t cond, logic [PC_W-1:0] target,
                                  logic act_we, act_t act, logic last);
        uword_t w;
        w.op = op;
        w.src = src;
        w.cond = cond;
        w.target = target;
        w.act_we = act_we;
        w.act = act;
        w.last = last;
        return w;
    endfunction

    function automatic uword_t ucode_rom(logic [PC_W-1:0] pc);
        uword_t w;
        unique case (pc)
            5'd0: w = uw(OP_MUL_PTS, SRC_MUL, C_NEVER, '0, 1'b0, ACT_ACCEL, 1'b0);
            5'd1: w = uw(OP_DIV_PREP, SRC_MUL, C_NEVER, '0, 1'b0, ACT_ACCEL, 1'b0);
            5'd2: w = uw(OP_MUL_MAGIC, SRC_MUL, C_NEVER, '0, 1'b0, ACT_ACCEL, 1'b0);
            5'd3: w = uw(OP_GAPS, SRC_MUL, C_NEVER, '0, 1'b0, ACT_ACCEL, 1'b0);
            5'd4: w = uw(OP_NOP, SRC_MUL, C_NO_LEAD, UA_ACCEL, 1'b1, ACT_ACCEL, 1'b0);
            5'd5: w = uw(OP_NOP, SRC_MUL, C_EMERG, UA_EMERG, 1'b0, ACT_ACCEL, 1'b0);
            5'd6: w = uw(OP_NOP, SRC_MUL, C_BRAKE, UA_BRAKE, 1'b0, ACT_ACCEL, 1'b0);
            5'd7: w = uw(OP_NOP, SRC_MUL, C_AT_MAX, UA_HOLD, 1'b1, ACT_ACCEL, 1'b0);
            5'd8: w = uw(OP_DIV_PREP, SRC_JERK, C_NEVER, '0, 1'b0, ACT_ACCEL, 1'b0);
            5'd9: w = uw(OP_MUL_MAGIC, SRC_MUL, C_NEVER, '0, 1'b0, ACT_ACCEL, 1'b0);
            5'd10: w = uw(OP_ACC_ADD, SRC_MUL, C_NEVER, '0, 1'b0, ACT_ACCEL, 1'b0);
            5'd11: w = uw(OP_DIV_PREP, SRC_ACC, C_NEVER, '0, 1'b0, ACT_ACCEL, 1'b0);
            5'd12: w = uw(OP_MUL_MAGIC, SRC_MUL, C_NEVER, '0, 1'b0, ACT_ACCEL, 1'b0);
            5'd13: w = uw(OP_VEL_CAP, SRC_MUL, C_ALWAYS, UA_STORE, 1'b0, ACT_ACCEL, 1'b0);
            5'd14: w = uw(OP_NOP, SRC_MUL, C_BRAKE_HOLD, UA_HOLD, 1'b1, ACT_BRAKE, 1'b0);
            5'd15: w = uw(OP_DIV_PREP, SRC_JERK, C_NEVER, '0, 1'b0, ACT_ACCEL, 1'b0);
            5'd16: w = uw(OP_MUL_MAGIC, SRC_MUL, C_NEVER, '0, 1'b0, ACT_ACCEL, 1'b0);
            5'd17: w = uw(OP_ACC_SUB, SRC_MUL, C_NEVER, '0, 1'b0, ACT_ACCEL, 1'b0);
            5'd18: w = uw(OP_DIV_PREP, SRC_ACC, C_NEVER, '0, 1'b0, ACT_ACCEL, 1'b0);
            5'd19: w = uw(OP_MUL_MAGIC, SRC_MUL, C_NEVER, '0, 1'b0, ACT_ACCEL, 1'b0);
            5'd20: w = uw(OP_VEL_FLOOR, SRC_MUL, C_ALWAYS, UA_STORE, 1'b0, ACT_ACCEL, 1'b0);
            5'd21: w = uw(OP_ACC_NEG, SRC_MUL, C_NEVER, '0, 1'b1, ACT_EMERGENCY, 1'b0);
            5'd22: w = uw(OP_DIV_PREP, SRC_ACC, C_NEVER, '0, 1'b0, ACT_ACCEL, 1'b0);
            5'd23: w = uw(OP_MUL_MAGIC, SRC_MUL, C_NEVER, '0, 1'b0, ACT_ACCEL, 1'b0);
            5'd24: w = uw(OP_VEL_EMERG, SRC_MUL, C_ALWAYS, UA_STORE, 1'b0, ACT_ACCEL, 1'b0);
            5'd25: w = uw(OP_HOLD, SRC_MUL, C_NEVER, '0, 1'b0, ACT_ACCEL, 1'b0);
            5'd26: w = uw(OP_STORE, SRC_MUL, C_NEVER, '0, 1'b0, ACT_ACCEL, 1'b1);
            default: w = uw(OP_STORE, SRC_MUL, C_NEVER, '0, 1'b0, ACT_ACCEL, 1'b1);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- src/jerk_limited_follow_speed_control_top.sv -----
// Jerk-limited follow speed control, one beat per planning tick.
// The item channel (item_valid, item_stall, item_data) carries the lead vehicle
// and path snapshot; the result channel (result_valid, result_stall, result_data)
// returns the new commanded acceleration, velocity and the chosen action.
// Configuration registers are written through cfg_write, cfg_index and cfg_data
// and the user must write them only while idle, which the block does not enforce;
// writes to unknown indexes are ignored. A small microprogram in a constant table
// runs each beat on two multipliers; every multiply by 0.02 is a reciprocal
// multiply on the shared second one. The last program step on the path taken
// loads the output register with the result.
// The program runs one item at a time, so item_stall is high while it runs and a
// new beat is taken the cycle after the result is written.
// The result register decouples the two sides: if result_stall holds a result,
// the next item is still taken, and its final step waits until the register frees.
// Reset clears the commanded acceleration and velocity to zero, loads the default
// configuration and leaves both channels empty.
`timescale 1ns / 1ps
`default_nettype none

module jerk_limited_follow_speed_control_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [jlfsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [jlfsc_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire jlfsc_pkg::item_t                    item_data,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output jlfsc_pkg::result_t                       result_data
);
    import jlfsc_pkg::*;

    logic [VEL_W-1:0] max_velocity_reg;
    logic [MACC_W-1:0] max_accel_reg;
    logic [JERK_W-1:0] max_jerk_reg;
    logic [DIST_W-1:0] safety_distance_reg;
    logic [DIST_W-1:0] near_distance_reg;

    logic signed [ACC_W-1:0] accel_reg;
    logic [VEL_W-1:0] velocity_reg;

    logic running_reg;
    logic [PC_W-1:0] pc_reg;
    item_t item_reg;
    act_t action_reg;

    logic [MUL_W-1:0] mul_reg;
    logic [PROD_W-1:0] dmag_reg;
    logic dneg_reg;
    logic signed [GAP_W-1:0] gap_end_reg;
    logic signed [GAP_W-1:0] gap_now_reg;
    logic [VEL_W-1:0] target_reg;
    logic signed [AW_W-1:0] a_work_reg;
    logic signed [VW_W-1:0] v_work_reg;

    logic result_valid_reg;
    result_t result_reg;

    uword_t uw_cur;
    logic item_take;
    logic store_block;
    logic step_go;
    logic cond_true;

    logic [PTS_W-1:0] pts_lim;
    logic [PROD_W-1:0] pts_prod;
    logic [MUL_W-1:0] magic_prod;
    logic [QM_W-1:0] q_mag;
    logic signed [Q_W-1:0] q_s;
    logic signed [POS_W:0] div_x;
    logic [POS_W:0] div_abs;
    logic signed [VW_W-1:0] a_sum;
    logic signed [VW_W-1:0] a_dif;
    logic signed [VW_W-1:0] acc_hi;
    logic signed [VW_W-1:0] acc_lo;
    logic signed [VW_W-1:0] v_sum;
    logic signed [VW_W-1:0] v_one;
    logic signed [VW_W-1:0] v_max;
    logic signed [GAP_W-1:0] near_dist_s;
    logic signed [GAP_W-1:0] safe_dist_s;
    logic [VEL_W-1:0] v_store;

    assign uw_cur = ucode_rom(pc_reg);
    assign item_stall = running_reg;
    assign item_take = item_valid && !running_reg;
    assign store_block = (uw_cur.op == OP_STORE) && result_valid_reg && result_stall;
    assign step_go = running_reg && !store_block;

    assign result_valid = result_valid_reg;
    assign result_data = result_reg;

    assign pts_lim = (item_reg.queued_points > MAX_PATH_POINTS) ? MAX_PATH_POINTS
                                                                 : item_reg.queued_points;
    assign pts_prod = PROD_W'(pts_lim) * PROD_W'(item_reg.lead_speed);
    assign magic_prod = MUL_W'(dmag_reg) * MUL_W'(DIV_MAGIC);
    assign q_mag = mul_reg[MUL_W-1:DIV_SHIFT];
    assign q_s = dneg_reg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

    assign a_sum = VW_W'(accel_reg) + VW_W'(q_s);
    assign a_dif = VW_W'(accel_reg) - VW_W'(q_s);
    assign acc_hi = $signed({{(VW_W - MACC_W){1'b0}}, max_accel_reg});
    assign acc_lo = -acc_hi;
    assign v_sum = $signed({{(VW_W - VEL_W){1'b0}}, velocity_reg}) + VW_W'(q_s);
    assign v_one = $signed({{(VW_W - VEL_W){1'b0}}, FX_ONE});
    assign v_max = $signed({{(VW_W - VEL_W){1'b0}}, max_velocity_reg});
    assign near_dist_s = $signed({{(GAP_W - DIST_W){1'b0}}, near_distance_reg});
    assign safe_dist_s = $signed({{(GAP_W - DIST_W){1'b0}}, safety_distance_reg});

    always_comb
    begin
        case (uw_cur.src)
            SRC_MUL: div_x = $signed({2'b0, mul_reg[PROD_W-1:0]});
            SRC_JERK: div_x = $signed({{(POS_W + 1 - JERK_W){1'b0}}, max_jerk_reg});
            SRC_ACC: div_x = (POS_W + 1)'(a_work_reg);
            default: div_x = '0;
        endcase
        div_abs = div_x[POS_W] ? (POS_W + 1)'(-div_x) : (POS_W + 1)'(div_x);
    end

    always_comb
    begin
        unique case (uw_cur.cond)
            C_NEVER: cond_true = 1'b0;
            C_ALWAYS: cond_true = 1'b1;
            C_NO_LEAD: cond_true = !item_reg.lead_present;
            C_EMERG: cond_true = (gap_now_reg <= near_dist_s) || (gap_end_reg <= near_dist_s);
            C_BRAKE: cond_true = gap_end_reg < safe_dist_s;
            C_AT_MAX: cond_true = velocity_reg == max_velocity_reg;
            C_BRAKE_HOLD: cond_true = (velocity_reg == FX_ONE) || (velocity_reg <= target_reg);
            default: cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        if (v_work_reg < 0)
        begin
            v_store = '0;
        end
        else if (v_work_reg[VW_W-2:VEL_W] != '0)
        begin
            v_store = '1;
        end
        else
        begin
            v_store = v_work_reg[VEL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_velocity_reg <= RST_MAX_VELOCITY;
            max_accel_reg <= RST_MAX_ACCEL;
            max_jerk_reg <= RST_MAX_JERK;
            safety_distance_reg <= RST_SAFETY_DISTANCE;
            near_distance_reg <= RST_MIN_DISTANCE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MAX_VELOCITY: max_velocity_reg <= cfg_data[VEL_W-1:0];
                REG_MAX_ACCEL: max_accel_reg <= cfg_data[MACC_W-1:0];
                REG_MAX_JERK: max_jerk_reg <= cfg_data[JERK_W-1:0];
                REG_SAFETY_DISTANCE: safety_distance_reg <= cfg_data[DIST_W-1:0];
                REG_MIN_DISTANCE: near_distance_reg <= cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            pc_reg <= '0;
            accel_reg <= '0;
            velocity_reg <= '0;
            result_valid_reg <= 1'b0;
            action_reg <= ACT_ACCEL;
        end
        else
        begin
            if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            if (item_take)
            begin
                running_reg <= 1'b1;
                pc_reg <= '0;
            end
            else if (step_go)
            begin
                if (uw_cur.act_we)
                begin
                    action_reg <= uw_cur.act;
                end
                if (uw_cur.op == OP_STORE)
                begin
                    accel_reg <= a_work_reg[ACC_W-1:0];
                    velocity_reg <= v_store;
                    result_valid_reg <= 1'b1;
                end
                if (uw_cur.last)
                begin
                    running_reg <= 1'b0;
                end
                pc_reg <= cond_true ? uw_cur.target : PC_W'(pc_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg <= item_data;
        end
        if (step_go && (uw_cur.op == OP_STORE))
        begin
            result_reg.accel_out <= a_work_reg[ACC_W-1:0];
            result_reg.velocity_out <= v_store;
            result_reg.action <= action_reg;
        end
        if (step_go)
        begin
            case (uw_cur.op)
                OP_MUL_PTS: mul_reg <= MUL_W'(pts_prod);
                OP_DIV_PREP:
                begin
                    dneg_reg <= div_x[POS_W];
                    dmag_reg <= div_abs[PROD_W-1:0] + DIV_ROUND;
                end
                OP_MUL_MAGIC: mul_reg <= magic_prod;
                OP_GAPS:
                begin
                    gap_end_reg <= $signed({2'b0, item_reg.lead_position}) + GAP_W'(q_s)
                                   - $signed({2'b0, item_reg.path_end_position});
                    gap_now_reg <= $signed({2'b0, item_reg.lead_position})
                                   - $signed({2'b0, item_reg.ego_position});
                    target_reg <= (item_reg.lead_speed > FX_TWO) ? item_reg.lead_speed - FX_TWO
                                                                 : item_reg.lead_speed >> 1;
                end
                OP_ACC_ADD: a_work_reg <= AW_W'((a_sum > acc_hi) ? acc_hi : a_sum);
                OP_ACC_SUB: a_work_reg <= AW_W'((a_dif < acc_lo) ? acc_lo : a_dif);
                OP_ACC_NEG: a_work_reg <= AW_W'(acc_lo);
                OP_VEL_CAP: v_work_reg <= (v_sum > v_max) ? v_max : v_sum;
                OP_VEL_FLOOR: v_work_reg <= (v_sum < v_one) ? v_one : v_sum;
                OP_VEL_EMERG:
                begin
                    if (v_sum <= v_one)
                    begin
                        v_work_reg <= v_one;
                        a_work_reg <= '0;
                    end
                    else
                    begin
                        v_work_reg <= v_sum;
                    end
                end
                OP_HOLD:
                begin
                    a_work_reg <= '0;
                    v_work_reg <= $signed({{(VW_W - VEL_W){1'b0}}, velocity_reg});
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/jlfsc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module jlfsc_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             item_valid,
    input wire logic                             item_stall,
    input wire logic                             result_valid,
    input wire logic                             result_stall,
    input wire jlfsc_pkg::result_t               result_data
);
    import jlfsc_pkg::*;

    // An accepted item keeps the block busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("item channel not stalled after a beat was taken");

    // A result only appears at the end of a program run.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result appeared without a running item");

    // A stalled result beat holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
        else $error("stalled result beat changed");

    // Emergency braking never takes the velocity below the floor.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_data.action == ACT_EMERGENCY)
            |-> result_data.velocity_out >= FX_ONE)
        else $error("emergency result below velocity floor");

endmodule

bind jerk_limited_follow_speed_control_top jlfsc_checker u_jlfsc_checker (
    .clk(clk),
    .rst_n(rst_n),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_data(result_data)
);

`default_nettype wire
